// File: hw/rtl/scs_pkg.sv
// scs_pkg: shared widths and constants for the shrinking cone segmenter
// no dependencies
package scs_pkg;
  localparam int unsigned MaxPointsDefault = 16777216;
  localparam int unsigned IdxW = 24;
  localparam int unsigned EpsW = 31;
  localparam logic [30:0] EpsReset = 31'd65536;
  localparam logic signed [47:0] S48Max = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48Min = {1'b1, {47{1'b0}}};
  localparam logic [1:0] AddrEps = 2'd0;
endpackage

// File: hw/rtl/scs_if.sv
// scs_if: valid/ready channel interfaces for points and segments
// depends on scs_pkg
interface scs_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_key;
  logic signed [31:0] point_position;
  logic last_point;
  modport source (output valid, point_key, point_position, last_point, input ready);
  modport sink (input valid, point_key, point_position, last_point, output ready);
endinterface

interface scs_seg_if;
  logic valid;
  logic ready;
  logic [scs_pkg::IdxW-1:0] first_index;
  logic [scs_pkg::IdxW-1:0] final_index;
  logic signed [47:0] seg_slope;
  logic signed [63:0] seg_intercept;
  logic last_segment;
  modport source (output valid, first_index, final_index, seg_slope, seg_intercept,
                  last_segment, input ready);
  modport sink (input valid, first_index, final_index, seg_slope, seg_intercept,
                last_segment, output ready);
endinterface

// File: hw/rtl/scs_div.sv
// scs_div: iterative signed divider, one quotient bit per cycle, truncation toward zero
// no dependencies
module scs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] dabs;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  // restoring step
  assign trial = {rem[63:0], q[63]} - {1'b0, dabs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd0;
      rem  <= 64'd0;
      q    <= num[63] ? 64'(-num) : num;
      dabs <= den[63] ? 64'(-den) : den;
      neg  <= num[63] ^ den[63];
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = neg ? 64'(-q) : q;
endmodule

// File: hw/rtl/shrinking_cone_segmenter.sv
// shrinking_cone_segmenter: streaming piecewise linear segmentation, top level
// depends on scs_pkg, scs_if, scs_div
//
//  channel | dir | beat
//  pts     | in  | point_key, point_position, last_point
//  segs    | out | first_index, final_index, seg_slope, seg_intercept, last_segment
//  apb     | in  | error_bound at address 0
//
// a point that opens a segment passes through S_IDLE and S_AFTER; one that extends
// the open segment runs two passes of the 64-step divider.
// a point whose key equals the anchor's skips the divider and closes the open segment.
// each segment beat passes through the midpoint, two partial products and subtract,
// then waits for segs.ready. rst clears control state, error_bound to 65536.
module shrinking_cone_segmenter #(
  parameter longint unsigned MAX_POINTS = scs_pkg::MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst,
  scs_point_if.sink   pts,
  scs_seg_if.source   segs,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV_LO, S_WAIT_LO, S_DIV_HI, S_WAIT_HI, S_CONE,
    S_EM_MID, S_EM_MUL, S_EM_LO, S_EM_SUB, S_OUT, S_AFTER
  } state_t;

  state_t state;
  logic [30:0] error_bound;
  logic signed [31:0] anchor_key, anchor_position, key, pos;
  logic signed [47:0] cone_low, cone_high, lo, hi;
  logic [23:0] segment_first, segment_final, point_counter, idx;
  logic segment_open, last, brk_pending;
  logic signed [48:0] slope_sum;
  logic signed [47:0] slope;
  logic signed [63:0] prod_hi;
  logic signed [63:0] prod;

  // divider
  logic div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic signed [63:0] dx, dy;
  assign dx = 64'(key) - 64'(anchor_key);
  assign dy = 64'(pos) - 64'(anchor_position);
  scs_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(dx),
                 .done(div_done), .quo(div_quo));

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'(scs_pkg::S48Max)) return scs_pkg::S48Max;
    if (v < 64'(scs_pkg::S48Min)) return scs_pkg::S48Min;
    return v[47:0];
  endfunction

  // mid slope, truncated toward zero, zero for a one-point segment
  logic [48:0] slope_rnd;
  logic signed [47:0] slope_mid;
  assign slope_rnd = slope_sum + {48'd0, slope_sum[48] & slope_sum[0]};
  assign slope_mid = (segment_first == segment_final) ? '0 : $signed(slope_rnd[48:1]);

  // slope * key split in two partial products, upper 32 and lower 16 slope bits
  logic signed [63:0] prod_hi_w;
  logic signed [48:0] prod_lo_w;
  assign prod_hi_w = $signed(slope_mid[47:16]) * anchor_key;
  assign prod_lo_w = $signed({1'b0, slope[15:0]}) * anchor_key;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == scs_pkg::AddrEps) ? {1'b0, error_bound} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) error_bound <= scs_pkg::EpsReset;
    else if (psel && penable && pwrite && paddr == scs_pkg::AddrEps)
      error_bound <= pwdata[30:0];
  end

  assign pts.ready = (state == S_IDLE);
  logic signed [47:0] nl, nh;
  assign nl = (lo > cone_low) ? lo : cone_low;
  assign nh = (hi < cone_high) ? hi : cone_high;
  logic [23:0] cnt_inc;
  assign cnt_inc = (64'(point_counter) + 64'd1 >= 64'(MAX_POINTS)) ? 24'd0
                   : point_counter + 24'd1;

  // sequencer
  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      segs.valid <= 1'b0;
      segment_open <= 1'b0;
      point_counter <= 24'd0;
      anchor_key <= '0;
      anchor_position <= '0;
      cone_low <= scs_pkg::S48Min;
      cone_high <= scs_pkg::S48Max;
      segment_first <= '0;
      segment_final <= '0;
    end else begin
      case (state)
        S_IDLE: if (pts.valid) begin
          key <= pts.point_key;
          pos <= pts.point_position;
          last <= pts.last_point;
          idx <= point_counter;
          brk_pending <= 1'b0;
          if (!segment_open) begin
            anchor_key <= pts.point_key;
            anchor_position <= pts.point_position;
            cone_low <= scs_pkg::S48Min;
            cone_high <= scs_pkg::S48Max;
            segment_first <= point_counter;
            segment_final <= point_counter;
            segment_open <= 1'b1;
            state <= S_AFTER;
          end else if (pts.point_key == anchor_key) begin
            brk_pending <= 1'b1;
            state <= S_EM_MID;
          end else begin
            state <= S_DIV_LO;
          end
        end
        S_DIV_LO: begin
          div_num <= (dy - 64'(error_bound)) <<< 16;
          div_start <= 1'b1;
          state <= S_WAIT_LO;
        end
        S_WAIT_LO: if (div_done) begin
          lo <= sat48(div_quo);
          state <= S_DIV_HI;
        end
        S_DIV_HI: begin
          div_num <= (dy + 64'(error_bound)) <<< 16;
          div_start <= 1'b1;
          state <= S_WAIT_HI;
        end
        S_WAIT_HI: if (div_done) begin
          hi <= sat48(div_quo);
          state <= S_CONE;
        end
        S_CONE: begin
          if (nl > nh) begin
            brk_pending <= 1'b1;
            state <= S_EM_MID;
          end else begin
            cone_low <= nl;
            cone_high <= nh;
            segment_final <= idx;
            state <= S_AFTER;
          end
        end
        S_EM_MID: begin
          slope_sum <= 49'(cone_low) + 49'(cone_high);
          state <= S_EM_MUL;
        end
        S_EM_MUL: begin
          slope <= slope_mid;
          segs.seg_slope <= slope_mid;
          prod_hi <= prod_hi_w;
          state <= S_EM_LO;
        end
        S_EM_LO: begin
          prod <= prod_hi + 64'(prod_lo_w >>> 16);
          state <= S_EM_SUB;
        end
        S_EM_SUB: begin
          segs.seg_intercept <= 64'(anchor_position) - prod;
          segs.first_index <= segment_first;
          segs.final_index <= segment_final;
          segs.last_segment <= !brk_pending;
          segs.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (segs.ready) begin
          segs.valid <= 1'b0;
          if (brk_pending) begin
            brk_pending <= 1'b0;
            anchor_key <= key;
            anchor_position <= pos;
            cone_low <= scs_pkg::S48Min;
            cone_high <= scs_pkg::S48Max;
            segment_first <= idx;
            segment_final <= idx;
            state <= S_AFTER;
          end else begin
            segment_open <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_AFTER: begin
          if (last) begin
            last <= 1'b0;
            point_counter <= 24'd0;
            state <= S_EM_MID;
          end else begin
            point_counter <= cnt_inc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
